>>> hdl/cesc_pkg.sv
// shared types, constants and month tables for the epoch seconds converter
package cesc_pkg;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 72;

  localparam logic [16:0] EPOCH_BIAS_DAYS = 17'((70 * 365) + 17);
  localparam logic [16:0] SECS_PER_DAY    = 17'd86400;
  localparam logic [16:0] SECS_PER_HOUR   = 17'd3600;
  localparam logic [16:0] DAYS_PER_YEAR   = 17'd365;
  localparam logic [7:0]  YEAR_OFFSET     = 8'd100;
  localparam logic [7:0]  YEAR_LAST       = 8'd199;

  // reciprocals, rounded up, with their shift amounts
  localparam logic [25:0] RCP_DAY  = 26'd50903317;  // x / 675, shift 35
  localparam logic [25:0] RCP_WEEK = 26'd149797;    // x / 7, shift 20
  localparam logic [25:0] RCP_HOUR = 26'd149131;    // x / 3600, shift 29
  localparam logic [25:0] RCP_YEAR = 26'd91930;     // x / 365, shift 25
  localparam logic [25:0] RCP_MIN  = 26'd2185;      // x / 60, shift 17

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_C2S_DAYS,
    ST_C2S_MUL,
    ST_C2S_SUM,
    ST_S2C_DIVD,
    ST_S2C_TODM,
    ST_S2C_TOD,
    ST_S2C_WDAY,
    ST_S2C_HOUR,
    ST_S2C_YEAR,
    ST_S2C_MIN,
    ST_S2C_MON
  } cesc_state_t;

  typedef enum logic [3:0] {
    STEP_NOP,
    STEP_C2S_DAYS,
    STEP_C2S_MUL,
    STEP_C2S_SUM,
    STEP_S2C_DIVD,
    STEP_S2C_TODM,
    STEP_S2C_TOD,
    STEP_S2C_WDAY,
    STEP_S2C_HOUR,
    STEP_S2C_YEAR,
    STEP_S2C_MIN,
    STEP_S2C_MON
  } cesc_step_t;

  typedef struct packed {
    logic       load_in;
    cesc_step_t step;
    logic       load_out;
  } cesc_cmd_t;

  typedef struct packed {
    logic              year_oor;
    logic [2:0]        weekday;
    logic [5:0]        second;
    logic [5:0]        minute;
    logic [4:0]        hour;
    logic [4:0]        day;
    logic [3:0]        month;
    logic signed [7:0] year;
    logic [31:0]       seconds;
  } cesc_result_t;

  // days before the first of month idx (0 is January)
  function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && (idx >= 4'd2)) ? 9'd1 : 9'd0);
  endfunction

endpackage

>>> hdl/cesc_ctrl.sv
// sequencer for the converter: steps the datapath and owns the handshakes
module cesc_ctrl
  import cesc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_op,
  output logic      in_tready,
  input  logic      out_tready,
  output logic      out_tvalid,
  output cesc_cmd_t cmd
);

  cesc_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = in_op ? ST_S2C_DIVD : ST_C2S_DAYS;
        end
      end
      ST_C2S_DAYS: state_nxt = ST_C2S_MUL;
      ST_C2S_MUL:  state_nxt = ST_C2S_SUM;
      ST_C2S_SUM: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      ST_S2C_DIVD: state_nxt = ST_S2C_TODM;
      ST_S2C_TODM: state_nxt = ST_S2C_TOD;
      ST_S2C_TOD:  state_nxt = ST_S2C_WDAY;
      ST_S2C_WDAY: state_nxt = ST_S2C_HOUR;
      ST_S2C_HOUR: state_nxt = ST_S2C_YEAR;
      ST_S2C_YEAR: state_nxt = ST_S2C_MIN;
      ST_S2C_MIN:  state_nxt = ST_S2C_MON;
      ST_S2C_MON: begin
        if (slot_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready    = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.step     = STEP_NOP;
    cmd.load_out = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_C2S_DAYS: cmd.step = STEP_C2S_DAYS;
      ST_C2S_MUL:  cmd.step = STEP_C2S_MUL;
      ST_C2S_SUM: begin
        cmd.step     = STEP_C2S_SUM;
        cmd.load_out = slot_free;
      end
      ST_S2C_DIVD: cmd.step = STEP_S2C_DIVD;
      ST_S2C_TODM: cmd.step = STEP_S2C_TODM;
      ST_S2C_TOD:  cmd.step = STEP_S2C_TOD;
      ST_S2C_WDAY: cmd.step = STEP_S2C_WDAY;
      ST_S2C_HOUR: cmd.step = STEP_S2C_HOUR;
      ST_S2C_YEAR: cmd.step = STEP_S2C_YEAR;
      ST_S2C_MIN:  cmd.step = STEP_S2C_MIN;
      ST_S2C_MON: begin
        cmd.step     = STEP_S2C_MON;
        cmd.load_out = slot_free;
      end
      default: cmd.step = STEP_NOP;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> hdl/cesc_dp.sv
// datapath: input capture, shared reciprocal multiplier, calendar logic, result register
module cesc_dp
  import cesc_pkg::*;
(
  input  logic                   clk,
  input  cesc_cmd_t              cmd,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output cesc_result_t           result
);

  // captured input fields
  logic [31:0] secs_r;
  logic [6:0]  iyear_r;
  logic [3:0]  imonth_r;
  logic [4:0]  iday_r;
  logic [4:0]  ihour_r;
  logic [5:0]  iminute_r;
  logic [5:0]  isecond_r;

  // working registers
  logic [50:0] prod_r;
  logic [16:0] days_r, days_nxt;
  logic [16:0] tod_r, tod_nxt;
  logic [11:0] rem_r;
  logic [2:0]  wday_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r, second_r;
  logic [7:0]  year_r;
  logic [7:0]  year1_r;
  logic [8:0]  doy_r;
  cesc_result_t res_r, res_nxt;

  // shared multiplier operands
  logic [24:0] mul_a;
  logic [25:0] mul_b;

  // date to day count
  logic [7:0]  year9;
  logic [16:0] ystart0;
  logic [3:0]  midx;
  logic [16:0] days0;
  logic [16:0] tod0;

  // seconds to date helpers
  logic [15:0] q_day;
  logic [16:0] day_n;
  logic [16:0] q_week;
  logic [4:0]  q_hour;
  logic [5:0]  q_min;
  logic [7:0]  yr_dec;
  logic [16:0] start_a, start_b;
  logic        use_dec;
  logic        leap1;
  logic [3:0]  mon_idx;
  logic [8:0]  mon_base;

  assign q_day  = prod_r[50:35];
  assign day_n  = days_r + 17'd1;
  assign q_week = prod_r[36:20];
  assign q_hour = prod_r[33:29];
  assign q_min  = prod_r[22:17];

  always_comb begin
    year9 = {1'b0, iyear_r} + YEAR_OFFSET;
    ystart0 = 17'((year9 - 8'd1) >> 2) + 17'(year9) * DAYS_PER_YEAR;
    if (imonth_r == 4'd0) begin
      midx = 4'd0;
    end else if (imonth_r > 4'd12) begin
      midx = 4'd11;
    end else begin
      midx = imonth_r - 4'd1;
    end
    days0 = ystart0 + 17'(cum_days(year9[1:0] == 2'b00, midx)) + 17'(iday_r)
            - 17'd1 - EPOCH_BIAS_DAYS;
    tod0 = 17'(ihour_r) * SECS_PER_HOUR + 17'(iminute_r) * 17'd60 + 17'(isecond_r);
  end

  // year estimate is at most one too high
  always_comb begin
    yr_dec  = year_r - 8'd1;
    start_a = 17'(year_r) * DAYS_PER_YEAR + 17'((year_r - 8'd1) >> 2);
    start_b = 17'(yr_dec) * DAYS_PER_YEAR + 17'((yr_dec - 8'd1) >> 2);
    use_dec = days_r < start_a;
  end

  always_comb begin
    leap1   = year1_r[1:0] == 2'b00;
    mon_idx = 4'd0;
    for (int m = 1; m < 12; m++) begin
      if (doy_r >= cum_days(leap1, 4'(m))) mon_idx = 4'(m);
    end
    mon_base = cum_days(leap1, mon_idx);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.step)
      // the day product is kept alive while the final add waits for the slot
      STEP_C2S_MUL, STEP_C2S_SUM: begin
        mul_a = 25'(days_r);
        mul_b = 26'(SECS_PER_DAY);
      end
      STEP_S2C_DIVD: begin
        mul_a = secs_r[31:7];
        mul_b = RCP_DAY;
      end
      STEP_S2C_TODM: begin
        mul_a = 25'(q_day);
        mul_b = 26'(SECS_PER_DAY);
      end
      STEP_S2C_TOD: begin
        mul_a = 25'(days_r + 17'd1);
        mul_b = RCP_WEEK;
      end
      STEP_S2C_WDAY: begin
        mul_a = 25'(tod_r);
        mul_b = RCP_HOUR;
      end
      STEP_S2C_HOUR: begin
        mul_a = 25'(days_r);
        mul_b = RCP_YEAR;
      end
      STEP_S2C_YEAR: begin
        mul_a = 25'(rem_r);
        mul_b = RCP_MIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    days_nxt = days_r;
    tod_nxt  = tod_r;
    unique case (cmd.step)
      STEP_C2S_DAYS: begin
        days_nxt = days0;
        tod_nxt  = tod0;
      end
      STEP_S2C_TODM: days_nxt = 17'(q_day) + EPOCH_BIAS_DAYS;
      STEP_S2C_TOD:  tod_nxt  = 17'(secs_r - prod_r[31:0]);
      default: begin
        days_nxt = days_r;
        tod_nxt  = tod_r;
      end
    endcase
  end

  always_comb begin
    res_nxt = '0;
    if (cmd.step == STEP_C2S_SUM) begin
      res_nxt.seconds = prod_r[31:0] + {15'd0, tod_r};
    end else begin
      res_nxt.year     = 8'(year1_r - YEAR_OFFSET);
      res_nxt.month    = mon_idx + 4'd1;
      res_nxt.day      = 5'(doy_r - mon_base + 9'd1);
      res_nxt.hour     = hour_r;
      res_nxt.minute   = minute_r;
      res_nxt.second   = second_r;
      res_nxt.weekday  = wday_r;
      res_nxt.year_oor = (year1_r < YEAR_OFFSET) || (year1_r > YEAR_LAST);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      secs_r    <= in_tdata[31:0];
      iyear_r   <= in_tdata[38:32];
      imonth_r  <= in_tdata[42:39];
      iday_r    <= in_tdata[47:43];
      ihour_r   <= in_tdata[52:48];
      iminute_r <= in_tdata[58:53];
      isecond_r <= in_tdata[64:59];
    end
    prod_r <= {26'd0, mul_a} * {25'd0, mul_b};
    days_r <= days_nxt;
    tod_r  <= tod_nxt;
    if (cmd.step == STEP_S2C_WDAY) begin
      wday_r <= 3'(day_n - 17'(q_week) * 17'd7);
    end
    if (cmd.step == STEP_S2C_HOUR) begin
      hour_r <= q_hour;
      rem_r  <= 12'(tod_r - 17'(q_hour) * SECS_PER_HOUR);
    end
    if (cmd.step == STEP_S2C_YEAR) begin
      year_r <= prod_r[32:25];
    end
    if (cmd.step == STEP_S2C_MIN) begin
      minute_r <= q_min;
      second_r <= 6'(rem_r - 12'(q_min) * 12'd60);
      year1_r  <= use_dec ? yr_dec : year_r;
      doy_r    <= 9'(days_r - (use_dec ? start_b : start_a));
    end
    if (cmd.load_out) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

>>> hdl/calendar_epoch_seconds_converter_core.sv
// top level of the calendar / unix seconds converter
//
// channel  dir  handshake              payload
// in_      in   in_tvalid/in_tready    in_tuser opcode, in_tdata calendar fields and seconds
// out_     out  out_tvalid/out_tready  out_tdata result fields, out_tuser year range flag
//
// calendar to seconds: accept, day count, day multiply, final add
// seconds to calendar: the one shared multiplier works through five reciprocal divisions
//   and one product in turn
// synchronous active-low reset returns the sequencer to idle and empties the result slot
// a stalled result holds in the output register; a new item is still taken meanwhile,
//   and only the last step of the next item waits for the slot to drain
module calendar_epoch_seconds_converter_core
  import cesc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input item
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [31:0] in_seconds, [38:32] in_year, [42:39] in_month, [47:43] in_day,
  // [52:48] in_hour, [58:53] in_minute, [64:59] in_second, [71:65] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] opcode: 0 calendar to seconds, 1 seconds to calendar
  input  logic                   in_tuser,
  // result item
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] out_seconds, [39:32] out_year, [43:40] out_month, [48:44] out_day,
  // [53:49] out_hour, [59:54] out_minute, [65:60] out_second, [68:66] out_weekday,
  // [71:69] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] year_out_of_range
  output logic                   out_tuser
);

  cesc_cmd_t    cmd;
  cesc_result_t result;

  // sequencer: one state per datapath step
  cesc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  // datapath holds the operands, the shared multiplier and the result register
  cesc_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_tdata (in_tdata),
    .result   (result)
  );

  // pack result fields, lowest field first
  assign out_tdata = {3'd0, result.weekday, result.second, result.minute, result.hour,
                      result.day, result.month, result.year, result.seconds};
  assign out_tuser = result.year_oor;

`ifndef SYNTHESIS
  // an accepted item never completes in the very next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after accept");

  // only one item in flight: the input closes right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input still open while an item is in flight");

  // the range flag comes only with calendar results, which carry zero seconds
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[31:0] == 32'd0))
    else $error("range flag set on a seconds result");
`endif

endmodule

>>> dv/cesc_tb_pkg.sv
// conversion direction codes shared by the converter testbench files
`timescale 1ns / 100ps
package cesc_tb_pkg;

  // carried on in_tuser
  typedef enum logic {
    OP_TO_SECONDS  = 1'b0,
    OP_TO_CALENDAR = 1'b1
  } conv_op_t;

endpackage

>>> dv/cesc_result_checker.sv
// watches both converter channels, predicts each result and compares it
`timescale 1ns / 100ps
module cesc_result_checker
  import cesc_pkg::*;
  import cesc_tb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     errors,
  output int                     pending
);

  localparam int unsigned DAY_SECONDS  = 86400;
  localparam int unsigned HOUR_SECONDS = 3600;
  localparam int unsigned BIAS_1900_TO_1970 = 70 * 365 + 17;
  localparam int unsigned YEAR_BASE = 100;

  cesc_result_t expected_q[$];

  // days from 1900-01-01 to january 1st of year y (counted from 1900)
  function automatic int unsigned first_day_of(input int unsigned y);
    return (y - 1) / 4 + 365 * y;
  endfunction

  // days of year y before month idx (0 is january), every fourth year leap but year 0
  function automatic int unsigned days_before_month(input int unsigned y,
                                                    input int unsigned idx);
    int unsigned base;
    case (idx)
      0:       base = 0;
      1:       base = 31;
      2:       base = 59;
      3:       base = 90;
      4:       base = 120;
      5:       base = 151;
      6:       base = 181;
      7:       base = 212;
      8:       base = 243;
      9:       base = 273;
      10:      base = 304;
      default: base = 334;
    endcase
    return base + ((y % 4 == 0 && y != 0 && idx >= 2) ? 1 : 0);
  endfunction

  function automatic cesc_result_t convert_item(input conv_op_t op,
                                                input logic [IN_TDATA_W-1:0] d);
    cesc_result_t r;
    int unsigned yr, mon, dy, hr, mi, sc, days, tod, start, secs;
    int yrel;
    r = '0;
    if (op == OP_TO_SECONDS) begin
      yr  = d[38:32];
      yr  = yr + YEAR_BASE;
      mon = d[42:39];
      dy  = d[47:43];
      hr  = d[52:48];
      mi  = d[58:53];
      sc  = d[64:59];
      if (mon < 1) mon = 1;
      if (mon > 12) mon = 12;
      days = first_day_of(yr) + days_before_month(yr, mon - 1) + dy - 1 - BIAS_1900_TO_1970;
      secs = HOUR_SECONDS * hr + 60 * mi + sc + days * DAY_SECONDS;
      r.seconds = secs;
    end else begin
      secs = d[31:0];
      days = BIAS_1900_TO_1970 + secs / DAY_SECONDS;
      tod  = secs % DAY_SECONDS;
      r.hour = tod / HOUR_SECONDS;
      tod  = tod % HOUR_SECONDS;
      r.minute  = tod / 60;
      r.second  = tod % 60;
      r.weekday = (days + 1) % 7;
      // guess from days / 365 and walk back while the year starts too late
      yr = days / 365;
      start = first_day_of(yr);
      while (days < start && yr > 1) begin
        yr--;
        start = first_day_of(yr);
      end
      days = days - start;
      mon = 11;
      while (mon > 0 && days < days_before_month(yr, mon)) mon--;
      yrel = int'(yr) - int'(YEAR_BASE);
      r.year     = yrel[7:0];
      r.month    = mon + 1;
      r.day      = days - days_before_month(yr, mon) + 1;
      r.year_oor = (yrel < 0 || yrel > 99);
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin : watch
    cesc_result_t want, got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.seconds  = out_tdata[31:0];
        got.year     = out_tdata[39:32];
        got.month    = out_tdata[43:40];
        got.day      = out_tdata[48:44];
        got.hour     = out_tdata[53:49];
        got.minute   = out_tdata[59:54];
        got.second   = out_tdata[65:60];
        got.weekday  = out_tdata[68:66];
        got.year_oor = out_tuser;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, expected none actual %h %b",
                   $time, out_tdata, out_tuser);
        end else begin
          want = expected_q.pop_front();
          check_field("seconds", want.seconds, got.seconds);
          check_field("year", want.year, got.year);
          check_field("month", want.month, got.month);
          check_field("day", want.day, got.day);
          check_field("hour", want.hour, got.hour);
          check_field("minute", want.minute, got.minute);
          check_field("second", want.second, got.second);
          check_field("weekday", want.weekday, got.weekday);
          check_field("year_out_of_range", want.year_oor, got.year_oor);
          check_field("tdata padding", 32'd0, out_tdata[71:69]);
        end
      end
      if (in_tvalid && in_tready)
        expected_q.push_back(convert_item(conv_op_t'(in_tuser), in_tdata));
      pending = expected_q.size();
    end
  end

endmodule

>>> dv/tb_calendar_epoch_seconds_converter_core.sv
// stimulus and verdict for the calendar / unix seconds converter
`timescale 1ns / 100ps
module tb_calendar_epoch_seconds_converter_core;
  import cesc_pkg::*;
  import cesc_tb_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     pending_count;

  // sender gaps on or off, switched in stretches
  bit                     send_idle;

  calendar_epoch_seconds_converter_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cesc_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .errors     (fail_count),
    .pending    (pending_count)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // offers one item after a random gap (if send_idle), returns at the falling edge after acceptance
  task automatic send_item(input conv_op_t op, input logic [31:0] sec,
                           input logic [6:0] yr, input logic [3:0] mon,
                           input logic [4:0] dy, input logic [4:0] hr,
                           input logic [5:0] mi, input logic [5:0] sc);
    int gap;
    gap = send_idle ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    // padding, second, minute, hour, day, month, year, unix seconds
    in_tdata  <= {7'd0, sc, mi, hr, dy, mon, yr, sec};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // mostly in the nominal range, sometimes any value the field width allows
  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi,
                                             input int unsigned bits);
    if ($urandom_range(0, 4) == 0)
      return $urandom() & ((32'd1 << bits) - 1);
    return $urandom_range(lo, hi);
  endfunction

  task automatic send_random_item();
    conv_op_t op;
    logic [31:0] sec;
    op = conv_op_t'($urandom_range(0, 1));
    case ($urandom_range(0, 4))
      0:       sec = $urandom();
      // around a midnight
      1:       sec = $urandom_range(0, 49710) * 32'd86400 + $urandom_range(0, 4) - 2;
      // inside 2000..2099
      2:       sec = $urandom_range(32'd946684800, 32'd4102444799);
      3:       sec = $urandom_range(0, 200000);
      default: sec = $urandom_range(32'hFFF00000, 32'hFFFFFFFF);
    endcase
    // the unused half of each item still gets random content
    send_item(op, sec, 7'(pick_field(0, 99, 7)), 4'(pick_field(1, 12, 4)),
              5'(pick_field(1, 31, 5)), 5'(pick_field(0, 23, 5)),
              6'(pick_field(0, 59, 6)), 6'(pick_field(0, 59, 6)));
  endtask

  // stimulus and verdict
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    send_idle = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // calendar to seconds: field extremes and clamping
    send_item(OP_TO_SECONDS, 32'd0, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_SECONDS, 32'd0, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
    // month zero taken as january
    send_item(OP_TO_SECONDS, 32'd10, 7'd0, 4'd0, 5'd5, 5'd1, 6'd0, 6'd0);
    // months above december taken as december
    send_item(OP_TO_SECONDS, 32'd20, 7'd13, 4'd13, 5'd15, 5'd12, 6'd30, 6'd30);
    // every input bit high, year past 2099 wraps the result
    send_item(OP_TO_SECONDS, 32'hFFFFFFFF, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    // day zero is the last day of the month before
    send_item(OP_TO_SECONDS, 32'd0, 7'd1, 4'd3, 5'd0, 5'd0, 6'd0, 6'd0);
    // day past the month length runs into the next month
    send_item(OP_TO_SECONDS, 32'd0, 7'd3, 4'd2, 5'd31, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_SECONDS, 32'd0, 7'd4, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0);
    // 2100 treated as a leap year
    send_item(OP_TO_SECONDS, 32'd0, 7'd100, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_SECONDS, 32'd0, 7'd100, 4'd3, 5'd1, 5'd0, 6'd0, 6'd0);
    // excess hours, minutes and seconds carry
    send_item(OP_TO_SECONDS, 32'd0, 7'd50, 4'd6, 5'd15, 5'd31, 6'd63, 6'd63);

    // seconds to calendar: range ends, year range flag edges, leap day
    send_item(OP_TO_CALENDAR, 32'd0, 7'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'hFFFFFFFF, 7'd127, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63);
    send_item(OP_TO_CALENDAR, 32'd946684800, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd946684799, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd951782400, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd4102444799, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd4102444800, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'h7FFFFFFF, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd86399, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);
    send_item(OP_TO_CALENDAR, 32'd978307199, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0);

    // random part, sender gaps switched in stretches of 40 items
    for (int n = 0; n < 1750; n++) begin
      if (n % 40 == 0)
        send_idle = ($urandom_range(0, 3) != 0);
      send_random_item();
    end
    in_tvalid <= 1'b0;

    // drain, then give the sequencer time to show any stray result
    wait (pending_count == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls in stretches, plus two long hold-offs that
  // back the block up and stall its input while items keep coming
  initial begin : result_sink
    int  hold;
    int  taken;
    bit  sink_idle;
    out_tready = 1'b0;
    taken      = 0;
    sink_idle  = 1'b1;
    @(negedge clk);
    wait (rst_n);
    forever begin
      if (taken % 50 == 0)
        sink_idle = ($urandom_range(0, 3) != 0);
      if (taken == 40 || taken == 800)
        hold = 300;
      else
        hold = sink_idle ? $urandom_range(0, 19) : 0;
      if (hold > 0) begin
        out_tready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // run limit, several times the slowest legal run
  initial begin
    #(5_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
